[src/scnt_pkg.sv]
// Shared types and constants of the surjection counter.
package scnt_pkg;

  // Field widths of the request and the result, and of the internal registers and counters.
  localparam int unsigned SizeW   = 4;
  localparam int unsigned CountW  = 59;
  localparam int unsigned AccW    = 64;
  localparam int unsigned BinomW  = 16;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned StepW   = 3;
  localparam int unsigned DivCntW = 5;

  typedef logic [StepW-1:0] step_t;

  // Step addresses of the control program.
  localparam step_t StepIdle  = 3'd0;
  localparam step_t StepCheck = 3'd1;
  localparam step_t StepBmul  = 3'd2;
  localparam step_t StepBdiv  = 3'd3;
  localparam step_t StepTinit = 3'd4;
  localparam step_t StepTpow  = 3'd5;
  localparam step_t StepAcc   = 3'd6;
  localparam step_t StepEmit  = 3'd7;

  // Datapath operation of one control word.
  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_NOP   = 3'd1,
    OP_BMUL  = 3'd2,
    OP_BDIV  = 3'd3,
    OP_TINIT = 3'd4,
    OP_TPOW  = 3'd5,
    OP_ACC   = 3'd6,
    OP_EMIT  = 3'd7
  } op_e;

  // Jump condition of one control word; when false the step counter advances.
  typedef enum logic [2:0] {
    COND_NEXT     = 3'd0,
    COND_NO_REQ   = 3'd1,
    COND_TRIVIAL  = 3'd2,
    COND_DIV_BUSY = 3'd3,
    COND_POW_BUSY = 3'd4,
    COND_MORE_K   = 3'd5,
    COND_OUT_FULL = 3'd6
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ucode_t;

  // Status flags from the datapath, tested by the jump conditions.
  typedef struct packed {
    logic no_req;
    logic trivial;
    logic div_busy;
    logic pow_busy;
    logic more_k;
    logic out_full;
  } dp_status_t;

endpackage

[src/scnt_seq.sv]
// Step counter and control program of the surjection counter.
module scnt_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scnt_pkg::dp_status_t status_i,
  output scnt_pkg::ucode_t    uword_o
);

  localparam int unsigned NumSteps = 2 ** scnt_pkg::StepW;

  // One control word per step: operation, jump condition, jump target.
  localparam scnt_pkg::ucode_t Program [NumSteps] = '{
    '{scnt_pkg::OP_LOAD,  scnt_pkg::COND_NO_REQ,   scnt_pkg::StepIdle},
    '{scnt_pkg::OP_NOP,   scnt_pkg::COND_TRIVIAL,  scnt_pkg::StepEmit},
    '{scnt_pkg::OP_BMUL,  scnt_pkg::COND_NEXT,     scnt_pkg::StepIdle},
    '{scnt_pkg::OP_BDIV,  scnt_pkg::COND_DIV_BUSY, scnt_pkg::StepBdiv},
    '{scnt_pkg::OP_TINIT, scnt_pkg::COND_NEXT,     scnt_pkg::StepIdle},
    '{scnt_pkg::OP_TPOW,  scnt_pkg::COND_POW_BUSY, scnt_pkg::StepTpow},
    '{scnt_pkg::OP_ACC,   scnt_pkg::COND_MORE_K,   scnt_pkg::StepBmul},
    '{scnt_pkg::OP_EMIT,  scnt_pkg::COND_OUT_FULL, scnt_pkg::StepEmit}
  };

  scnt_pkg::step_t upc_q, upc_d;
  scnt_pkg::ucode_t uword;
  logic take_jump;

  assign uword   = Program[upc_q];
  assign uword_o = uword;

  always_comb begin
    unique case (uword.cond)
      scnt_pkg::COND_NEXT:     take_jump = 1'b0;
      scnt_pkg::COND_NO_REQ:   take_jump = status_i.no_req;
      scnt_pkg::COND_TRIVIAL:  take_jump = status_i.trivial;
      scnt_pkg::COND_DIV_BUSY: take_jump = status_i.div_busy;
      scnt_pkg::COND_POW_BUSY: take_jump = status_i.pow_busy;
      scnt_pkg::COND_MORE_K:   take_jump = status_i.more_k;
      scnt_pkg::COND_OUT_FULL: take_jump = status_i.out_full;
      default:                 take_jump = 1'b0;
    endcase
    // The last step wraps back to the idle step.
    upc_d = take_jump ? uword.target : upc_q + scnt_pkg::step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= scnt_pkg::StepIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

[src/scnt_datapath.sv]
// Operand registers, two multipliers, bit-serial divider and output register.
module scnt_datapath #(
  parameter int unsigned MAX_SET_SIZE = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  scnt_pkg::ucode_t                    uword_i,
  output scnt_pkg::dp_status_t                status_o,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [scnt_pkg::InDataW-1:0]        s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [scnt_pkg::OutDataW-1:0]       m_axis_tdata
);

  localparam logic [scnt_pkg::SizeW-1:0] SizeMax = scnt_pkg::SizeW'(MAX_SET_SIZE);

  logic [scnt_pkg::SizeW-1:0]   m_q, n_q, k_q, ecnt_q;
  logic [scnt_pkg::BinomW-1:0]  binom_q, num_q;
  logic [scnt_pkg::SizeW-1:0]   rem_q;
  logic [scnt_pkg::DivCntW-1:0] dcnt_q;
  logic [scnt_pkg::AccW-1:0]    term_q, sum_q;
  logic [scnt_pkg::CountW-1:0]  out_q;
  logic                         out_valid_q, out_valid_d;

  logic [scnt_pkg::SizeW-1:0]   dom_size, cod_size, dom_clamp, cod_clamp;
  logic [scnt_pkg::SizeW:0]     factor_wide;
  logic [scnt_pkg::SizeW-1:0]   factor;
  logic [scnt_pkg::BinomW+scnt_pkg::SizeW-1:0] bprod;
  logic [scnt_pkg::AccW+scnt_pkg::SizeW-1:0]   tprod;
  logic [scnt_pkg::SizeW:0]     rem_shift, rem_sub;
  logic                         qbit;
  logic                         accept, out_full;

  assign dom_size  = s_axis_tdata[scnt_pkg::SizeW-1:0];
  assign cod_size  = s_axis_tdata[2*scnt_pkg::SizeW-1:scnt_pkg::SizeW];
  assign dom_clamp = (dom_size > SizeMax) ? SizeMax : dom_size;
  assign cod_clamp = (cod_size > SizeMax) ? SizeMax : cod_size;

  assign s_axis_tready = (uword_i.op == scnt_pkg::OP_LOAD);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_full      = out_valid_q && !m_axis_tready;

  // Next falling factor n - k + 1, never zero while k <= n.
  assign factor_wide = {1'b0, n_q} - {1'b0, k_q} + (scnt_pkg::SizeW+1)'(1);
  assign factor      = factor_wide[scnt_pkg::SizeW-1:0];
  assign bprod       = binom_q * factor;
  assign tprod       = term_q * k_q;

  // One restoring division step: bring in the next numerator bit.
  assign rem_shift = {rem_q, num_q[scnt_pkg::BinomW-1]};
  assign qbit      = (rem_shift >= {1'b0, k_q});
  assign rem_sub   = qbit ? (rem_shift - {1'b0, k_q}) : rem_shift;

  always_comb begin
    status_o.no_req   = !s_axis_tvalid;
    status_o.trivial  = (m_q < n_q) || (n_q == '0);
    status_o.div_busy = (dcnt_q != '0);
    status_o.pow_busy = (ecnt_q != '0);
    status_o.more_k   = (k_q != n_q);
    status_o.out_full = out_full;
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (uword_i.op == scnt_pkg::OP_EMIT && !out_full) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (uword_i.op == scnt_pkg::OP_BMUL) begin
        dcnt_q <= scnt_pkg::DivCntW'(scnt_pkg::BinomW);
      end else if (uword_i.op == scnt_pkg::OP_BDIV && dcnt_q != '0) begin
        dcnt_q <= dcnt_q - scnt_pkg::DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (uword_i.op)
      scnt_pkg::OP_LOAD: begin
        if (accept) begin
          m_q     <= dom_clamp;
          n_q     <= cod_clamp;
          k_q     <= scnt_pkg::SizeW'(1);
          binom_q <= scnt_pkg::BinomW'(1);
          sum_q   <= '0;
        end
      end
      scnt_pkg::OP_NOP: ;
      scnt_pkg::OP_BMUL: begin
        num_q <= bprod[scnt_pkg::BinomW-1:0];
        rem_q <= '0;
      end
      scnt_pkg::OP_BDIV: begin
        if (dcnt_q != '0) begin
          num_q <= {num_q[scnt_pkg::BinomW-2:0], qbit};
          rem_q <= rem_sub[scnt_pkg::SizeW-1:0];
        end
      end
      scnt_pkg::OP_TINIT: begin
        binom_q <= num_q;
        term_q  <= scnt_pkg::AccW'(num_q);
        ecnt_q  <= m_q;
      end
      scnt_pkg::OP_TPOW: begin
        if (ecnt_q != '0) begin
          term_q <= tprod[scnt_pkg::AccW-1:0];
          ecnt_q <= ecnt_q - scnt_pkg::SizeW'(1);
        end
      end
      scnt_pkg::OP_ACC: begin
        // Odd n - k subtracts the term.
        if (n_q[0] ^ k_q[0]) begin
          sum_q <= sum_q - term_q;
        end else begin
          sum_q <= sum_q + term_q;
        end
        k_q <= k_q + scnt_pkg::SizeW'(1);
      end
      scnt_pkg::OP_EMIT: begin
        if (!out_full) begin
          out_q <= sum_q[scnt_pkg::CountW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = scnt_pkg::OutDataW'(out_q);

endmodule

[src/surjection_counter.sv]
// Top level of the surjection counter: sequencer and datapath.
//
// Counts the onto maps from an m-set to an n-set by inclusion-exclusion:
// the sum over k = 1..n of (-1)^(n-k) * C(n,k) * k^m, in 64-bit arithmetic.
// Requests enter on the s_axis channel (m and n, each clamped to
// MAX_SET_SIZE); each request gives exactly one result on m_axis.
// m < n, or n = 0, yields a count of zero.
//
// A request is taken in the idle step only. For each k the program runs
// the falling-product multiply, the bit-serial exact division by k, the
// seeding of the term, the power loop and the accumulation. One request
// is in flight at a time; the division and the two multipliers (16x4
// and 64x4) set the pace.
//
// Reset clears the step counter and the output valid flag; the block then
// waits in its idle step. The result sits in an output register: the next
// request is taken while it waits, and a stalled receiver only holds the
// sequencer in its emit step once the following result is ready.
module surjection_counter #(
  parameter int unsigned MAX_SET_SIZE = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [3:0] domain_size, [7:4] codomain_size
  input  logic [scnt_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [58:0] surjection_count, [63:59] zero
  output logic [scnt_pkg::OutDataW-1:0] m_axis_tdata
);

  scnt_pkg::ucode_t     uword;
  scnt_pkg::dp_status_t status;

  // Program sequencer: fetch one control word per cycle, jump on status.
  scnt_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .uword_o  (uword)
  );

  // Datapath driven by the current control word.
  scnt_datapath #(
    .MAX_SET_SIZE (MAX_SET_SIZE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .uword_i       (uword),
    .status_o      (status),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[src/scnt_checker.sv]
// Port checker of the surjection counter and its binding.
module scnt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [scnt_pkg::InDataW-1:0]  s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [scnt_pkg::OutDataW-1:0] m_axis_tdata
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result dropped or changed");

  // Padding bits above the count stay zero.
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[scnt_pkg::OutDataW-1:scnt_pkg::CountW] == '0)
    else $error("result padding not zero");

  // An accepted request makes the block busy for the next cycles.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("request taken while busy");

  // No result can appear in the cycle right after a request is taken.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

endmodule

bind surjection_counter scnt_checker u_scnt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
